@@ rtl/core/circular_heading_average_top_macros.svh @@
// Assertion macros shared by the circular heading average RTL.
`ifndef CIRCULAR_HEADING_AVERAGE_TOP_MACROS_SVH
`define CIRCULAR_HEADING_AVERAGE_TOP_MACROS_SVH

// Checks a property at every rising clock edge once reset has been released.
`define CHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define CHA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/core/cha_pkg.sv @@
// Package with the types, constants and tables of the circular heading average.
`default_nettype none
package cha_pkg;

  // Window depth and field widths.
  localparam int WINDOW   = 5;
  localparam int HEAD_W   = 16;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // CORDIC sizing.
  localparam int ITERS    = 24;
  localparam int ITER_W   = $clog2(ITERS);
  localparam int XY_W     = 34;
  localparam int Z_W      = 32;
  localparam int Q15_W    = 16;
  localparam int SUM_W    = Q15_W + $clog2(WINDOW + 1) + 1;

  // Rotation gain in Q4.30 and the half turn in angle units.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic [Z_W-1:0]         HALF_TURN   = 32'h8000_0000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROT,
    ST_ACC,
    ST_VSTART,
    ST_VEC,
    ST_DONE
  } cha_state_t;

  // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
  function automatic logic [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/circular_heading_average_top.sv @@
// Circular heading average: window store, shared iterative CORDIC and sequencer.
//
// One input beat carries a 16-bit heading (binary angle, 65536 per turn).
// It is written into a ring of the last WINDOW headings, and every heading of
// the ring is turned into a cosine and sine by one shared CORDIC unit that
// runs one micro-rotation per cycle. The summed vector then goes through the
// same unit in vectoring mode, and its direction leaves as one output beat
// with mean_heading and the zero_resultant flag.
// The single CORDIC unit runs its 24 iterations for each window entry
// and once more for the vector angle. A zero resultant skips the vectoring
// pass. One heading is worked on at a time: a new beat is accepted only
// once the sequencer is back in idle, its result moved to the output register.
// in_stall is high while the sequencer is busy. The finished result sits in
// an output register; the next heading is accepted while it waits, and only
// the hand-off of the following result waits for out_stall to drop.
// Reset (synchronous, rst_n low) clears the window to heading zero, the
// write slot, the sequencer and the output valid.
`default_nettype none
`include "circular_heading_average_top_macros.svh"
module circular_heading_average_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cha_pkg::HEAD_W-1:0] in_heading,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [cha_pkg::HEAD_W-1:0]     out_mean_heading,
  output logic                           out_zero_resultant
);
  import cha_pkg::*;

  cha_state_t state_r, state_nxt;

  logic [HEAD_W-1:0]          win_r [WINDOW];
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic [SLOT_W-1:0]          entry_r, entry_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic signed [XY_W-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [Z_W-1:0]             z_r, z_nxt;
  logic                       flip_r, flip_nxt;
  logic signed [SUM_W-1:0]    sum_c_r, sum_c_nxt, sum_s_r, sum_s_nxt;
  logic                       zero_r, zero_nxt;
  logic                       out_valid_r;
  logic [HEAD_W-1:0]          out_mean_r;
  logic                       out_zero_r;

  logic                       in_beat;
  logic                       last_iter;
  logic                       rot_mode;
  logic                       sigma;
  logic signed [XY_W-1:0]     x_sh, y_sh;
  logic [Z_W-1:0]             atan_v;
  logic [Z_W-1:0]             ang;
  logic signed [XY_W-1:0]     c_full, s_full;
  logic signed [Q15_W-1:0]    c_q, s_q;
  logic signed [XY_W-1:0]     vx0, vy0;
  logic                       res_load;

  // Rounds a Q4.30 value half up to Q1.15 and saturates it.
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    logic signed [Q15_W-1:0] q;
    r = (v + XY_W'(16384)) >>> 15;
    if (r > XY_W'(32767)) begin
      q = 16'sh7FFF;
    end else if (r < -XY_W'(32768)) begin
      q = 16'sh8000;
    end else begin
      q = r[Q15_W-1:0];
    end
    return q;
  endfunction

  assign in_beat   = in_valid && !in_stall;
  assign last_iter = (iter_r == ITER_W'(ITERS - 1));
  assign res_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Shared micro-rotation: direction from z in rotation mode, from y otherwise.
  assign rot_mode = (state_r == ST_ROT);
  assign sigma    = rot_mode ? !z_r[Z_W-1] : y_r[XY_W-1];
  assign x_sh     = x_r >>> iter_r;
  assign y_sh     = y_r >>> iter_r;
  assign atan_v   = atan_lut(iter_r);

  // Angle of the window entry being loaded; ST_LOAD folds the left half plane.
  assign ang = {win_r[entry_r], {(Z_W-HEAD_W){1'b0}}};

  // Cosine and sine of the finished rotation.
  assign c_full = flip_r ? -x_r : x_r;
  assign s_full = flip_r ? -y_r : y_r;
  assign c_q    = to_q15(c_full);
  assign s_q    = to_q15(s_full);

  // Summed vector scaled by 256 for the vectoring pass.
  assign vx0 = XY_W'(sum_c_r) <<< 8;
  assign vy0 = XY_W'(sum_s_r) <<< 8;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_beat) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_ROT;
      ST_ROT:    if (last_iter) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = (entry_r == SLOT_W'(WINDOW - 1)) ? ST_VSTART : ST_LOAD;
      ST_VSTART: state_nxt = (sum_c_r == '0 && sum_s_r == '0) ? ST_DONE : ST_VEC;
      ST_VEC:    if (last_iter) state_nxt = ST_DONE;
      ST_DONE:   if (res_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall           = (state_r != ST_IDLE);
    out_valid          = out_valid_r;
    out_mean_heading   = out_mean_r;
    out_zero_resultant = out_zero_r;
  end

  // Datapath next values.
  always_comb begin
    slot_nxt  = slot_r;
    entry_nxt = entry_r;
    iter_nxt  = iter_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    flip_nxt  = flip_r;
    sum_c_nxt = sum_c_r;
    sum_s_nxt = sum_s_r;
    zero_nxt  = zero_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          entry_nxt = '0;
          sum_c_nxt = '0;
          sum_s_nxt = '0;
        end
      end
      ST_LOAD: begin
        flip_nxt = ang[Z_W-1] ^ ang[Z_W-2];
        z_nxt    = (ang[Z_W-1] ^ ang[Z_W-2]) ? (ang ^ HALF_TURN) : ang;
        x_nxt    = CORDIC_GAIN;
        y_nxt    = '0;
        iter_nxt = '0;
      end
      ST_ROT, ST_VEC: begin
        if (sigma) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_v;
        end
        iter_nxt = iter_r + 1'b1;
      end
      ST_ACC: begin
        sum_c_nxt = sum_c_r + SUM_W'(c_q);
        sum_s_nxt = sum_s_r + SUM_W'(s_q);
        entry_nxt = (entry_r == SLOT_W'(WINDOW - 1)) ? '0 : entry_r + 1'b1;
      end
      ST_VSTART: begin
        zero_nxt = (sum_c_r == '0 && sum_s_r == '0);
        iter_nxt = '0;
        if (vx0 < 0) begin
          x_nxt = -vx0;
          y_nxt = -vy0;
          z_nxt = HALF_TURN;
        end else begin
          x_nxt = vx0;
          y_nxt = vy0;
          z_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      entry_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      entry_r <= entry_nxt;
      iter_r  <= iter_nxt;
      if (in_beat) begin
        win_r[slot_r] <= in_heading;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    flip_r  <= flip_nxt;
    sum_c_r <= sum_c_nxt;
    sum_s_r <= sum_s_nxt;
    zero_r  <= zero_nxt;
    if (res_load) begin
      out_zero_r <= zero_r;
      out_mean_r <= zero_r ? '0 : (z_r[Z_W-1:Z_W-HEAD_W] + HEAD_W'(z_r[Z_W-HEAD_W-1]));
    end
  end

  // Checks.
  `CHA_ASSERT(a_zero_mean, !(out_valid_r && out_zero_r) || out_mean_r == '0, "zero flag with nonzero mean")
  `CHA_ASSERT(a_slot_range, slot_r <= SLOT_W'(WINDOW - 1) && entry_r <= SLOT_W'(WINDOW - 1), "slot out of range")
  `CHA_ASSERT_NEXT(a_res_held, out_valid_r && out_stall && state_r != ST_DONE, out_valid_r, "result dropped while stalled")
  `CHA_ASSERT_NEXT(a_accept_idle, in_beat, state_r == ST_LOAD, "beat did not start a pass")

endmodule
`default_nettype wire
